// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pea_pkg.sv =====
// ----------------------------------------------------------------------------
// pea_pkg
// Shared codes, types and control structs of the palette expander.
// ----------------------------------------------------------------------------
package pea_pkg;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 32;
  localparam int COORD_W = 8;
  localparam int SIZE_W = 9;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_PAL  = 2'd0,
    OP_SRC  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // lookup order of one read: the pixel, then its neighbors
  typedef enum logic [2:0] {
    LK_CENTER = 3'd0,
    LK_RIGHT  = 3'd1,
    LK_LEFT   = 3'd2,
    LK_BELOW  = 3'd3,
    LK_ABOVE  = 3'd4
  } lookup_t;

  typedef enum logic [2:0] {
    RES_NONE = 3'd0,
    RES_ZERO = 3'd1,
    RES_SELF = 3'd2,
    RES_KEEP = 3'd3,
    RES_NB   = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     pal_we;
    logic     src_we;
    logic     mod_step;
    logic     calc;
    logic     src_rd;
    logic     pal_rd;
    logic     save_center;
    logic     next_k;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic in_image;
    logic opaque;
    logic nb_avail;
    logic is_center;
    logic mod_last;
  } status_t;

endpackage

// ===== rtl/palette_expand_alpha_bleed.sv =====
// ----------------------------------------------------------------------------
// palette_expand_alpha_bleed
// Indexed color expansion with color bleed into transparent pixels.
// ----------------------------------------------------------------------------
// One item at a time; start is taken while busy is low, and busy drops again
// between items. A palette write is busy in S_WPAL only. A source write is
// busy in S_WSRC, and before it in S_MOD when MAX_SIDE*MAX_SIDE is below 65536,
// since the address is then reduced modulo the store depth by a reciprocal
// multiply, then a correcting subtract, both in S_MOD. A read passes S_CALC,
// then n lookups, n being the lookups needed (1 to 5: the pixel, then right,
// left, below, above neighbors until one is opaque), and strobes done in S_OUT;
// each lookup is a source-store read (S_SRD) followed by a palette read (S_PRD)
// on single-ported memories, then a check (S_PCHK). The result is valid on the
// ports only for the single cycle that done is high: the receiver has to take
// it then. Reads outside the configured size go from S_CALC straight to S_OUT,
// with a zero result and coord_ok low. Writes and ignored operations give no
// result. There is no clearing pass; memory entries hold garbage until
// written. The size registers may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_expand_alpha_bleed #(
  parameter int MAX_SIDE = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pea_pkg::OP_W-1:0]          operation,
  input  logic [pea_pkg::ADDR_W-1:0]        address,
  input  logic [pea_pkg::DATA_W-1:0]        write_data,
  input  logic [pea_pkg::COORD_W-1:0]       pixel_x,
  input  logic [pea_pkg::COORD_W-1:0]       pixel_y,
  output logic                              done,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha,
  output logic                              coord_ok,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pea_pkg::SIZE_W-1:0]        cfg_data
);

  localparam int SRC_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam bit NEED_WRAP = (SRC_DEPTH < (1 << pea_pkg::ADDR_W));

  pea_pkg::cmd_t    cmd;
  pea_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pea_ctrl #(
    .NEED_WRAP(NEED_WRAP)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  pea_datapath #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .address    (address),
    .write_data (write_data),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .coord_ok   (coord_ok)
  );

  logic rd_take, rgba_zero;
  assign rd_take   = start && !busy && (operation == pea_pkg::OP_READ);
  assign rgba_zero = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0) && (alpha == 8'd0);

  `CHK_NOW(a_done_busy, done, busy, "result strobe outside a busy item")
  `CHK_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `CHK_NEXT(a_read_busy, rd_take, busy, "read item not taken up")
  `CHK_NOW(a_outside_zero, done && !coord_ok, rgba_zero, "outside pixel with nonzero color")

endmodule

// ===== rtl/pea_ctrl.sv =====
// ----------------------------------------------------------------------------
// pea_ctrl
// Sequencer: walks writes, address wrap and the lookups of a read.
// ----------------------------------------------------------------------------
module pea_ctrl #(
  parameter bit NEED_WRAP = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pea_pkg::OP_W-1:0]       operation,
  input  pea_pkg::status_t               status,
  output pea_pkg::cmd_t                  cmd,
  output logic                           busy,
  output logic                           done
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WPAL = 9'b000000010,
    S_MOD  = 9'b000000100,
    S_WSRC = 9'b000001000,
    S_CALC = 9'b000010000,
    S_SRD  = 9'b000100000,
    S_PRD  = 9'b001000000,
    S_PCHK = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_sel = pea_pkg::RES_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (pea_pkg::op_t'(operation))
            pea_pkg::OP_PAL:  state_next = S_WPAL;
            pea_pkg::OP_SRC:  state_next = NEED_WRAP ? S_MOD : S_WSRC;
            pea_pkg::OP_READ: state_next = S_CALC;
            default:          state_next = S_IDLE;
          endcase
        end
      end
      S_WPAL: begin
        cmd.pal_we = 1'b1;
        state_next = S_IDLE;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) state_next = S_WSRC;
      end
      S_WSRC: begin
        cmd.src_we = 1'b1;
        state_next = S_IDLE;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (status.in_image) begin
          state_next = S_SRD;
        end else begin
          cmd.res_sel = pea_pkg::RES_ZERO;
          state_next = S_OUT;
        end
      end
      S_SRD: begin
        cmd.src_rd = 1'b1;
        state_next = S_PRD;
      end
      S_PRD: begin
        cmd.pal_rd = 1'b1;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        cmd.save_center = status.is_center;
        if (status.opaque) begin
          cmd.res_sel = status.is_center ? pea_pkg::RES_SELF : pea_pkg::RES_NB;
          state_next = S_OUT;
        end else if (status.nb_avail) begin
          cmd.next_k = 1'b1;
          state_next = S_SRD;
        end else begin
          // transparent and no opaque neighbor left: own color stands
          cmd.res_sel = status.is_center ? pea_pkg::RES_SELF : pea_pkg::RES_KEEP;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule

// ===== rtl/pea_datapath.sv =====
// ----------------------------------------------------------------------------
// pea_datapath
// Size registers, palette and source memories, address arithmetic, result.
// ----------------------------------------------------------------------------
module pea_datapath #(
  parameter int MAX_SIDE = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pea_pkg::cmd_t                     cmd,
  output pea_pkg::status_t                  status,
  input  logic                              cfg_we,
  input  logic [pea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pea_pkg::SIZE_W-1:0]        cfg_data,
  input  logic [pea_pkg::ADDR_W-1:0]        address,
  input  logic [pea_pkg::DATA_W-1:0]        write_data,
  input  logic [pea_pkg::COORD_W-1:0]       pixel_x,
  input  logic [pea_pkg::COORD_W-1:0]       pixel_y,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha,
  output logic                              coord_ok
);

  localparam int SRC_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int PW        = $clog2(SRC_DEPTH);
  localparam bit NEED_WRAP = (SRC_DEPTH < (1 << pea_pkg::ADDR_W));
  // floor(2^32 / depth): the quotient estimate is low by at most one
  localparam longint unsigned RECIP = (64'd1 << 32) / 64'(SRC_DEPTH);
  localparam logic [31:0] RECIP_W = 32'(RECIP);
  localparam logic [31:0] DEPTH_W = 32'(SRC_DEPTH);

  // size registers
  logic [pea_pkg::SIZE_W-1:0] width_reg, height_reg;
  logic [pea_pkg::SIZE_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= pea_pkg::SIZE_W'(1);
      height_reg <= pea_pkg::SIZE_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == pea_pkg::REG_WIDTH)  width_reg  <= cfg_data;
      if (cfg_index == pea_pkg::REG_HEIGHT) height_reg <= cfg_data;
    end
  end

  // clamp to the largest side the store holds
  assign w_eff = (32'(width_reg) > 32'(MAX_SIDE))  ? pea_pkg::SIZE_W'(MAX_SIDE) : width_reg;
  assign h_eff = (32'(height_reg) > 32'(MAX_SIDE)) ? pea_pkg::SIZE_W'(MAX_SIDE) : height_reg;

  // captured item
  logic [pea_pkg::ADDR_W-1:0]  addr_q;
  logic [pea_pkg::DATA_W-1:0]  data_q;
  logic [pea_pkg::COORD_W-1:0] x_q, y_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= address;
      data_q <= write_data;
      x_q    <= pixel_x;
      y_q    <= pixel_y;
    end
  end

  // source address reduction: reciprocal multiply, then one correcting subtract
  logic                       mod_cnt;
  logic [pea_pkg::ADDR_W-1:0] quot_q;
  logic [PW-1:0]              rem_q;
  logic [47:0]                quot_prod;
  logic [31:0]                rem_raw;

  assign quot_prod = 48'(addr_q) * 48'(RECIP_W);
  assign rem_raw   = 32'(addr_q) - 32'(quot_q) * DEPTH_W;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mod_cnt <= 1'b1;
    end else if (cmd.mod_step) begin
      mod_cnt <= 1'b0;
      if (mod_cnt) quot_q <= quot_prod[47:32];
      else         rem_q  <= (rem_raw >= DEPTH_W) ? PW'(rem_raw - DEPTH_W) : PW'(rem_raw);
    end
  end

  logic [PW-1:0] src_waddr;
  assign src_waddr = NEED_WRAP ? rem_q : PW'(32'(addr_q));

  // read position and neighbor flags
  logic [PW-1:0]          pos_q;
  logic [3:0]             nb_ok_q;
  pea_pkg::lookup_t       k_q;
  logic [31:0]            pos_full;
  logic                   in_image;
  logic [pea_pkg::SIZE_W-1:0] x9, y9;
  pea_pkg::lookup_t       k_next;
  logic                   nb_avail;

  assign x9 = pea_pkg::SIZE_W'(x_q);
  assign y9 = pea_pkg::SIZE_W'(y_q);
  assign in_image = (x9 < w_eff) && (y9 < h_eff);
  assign pos_full = 32'(x_q) * 32'(h_eff) + 32'(y_q);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      pos_q   <= pos_full[PW-1:0];
      k_q     <= pea_pkg::LK_CENTER;
      nb_ok_q <= {(y_q != '0), ((y9 + 9'd1) < h_eff),
                  (x_q != '0), ((x9 + 9'd1) < w_eff)};
    end else if (cmd.next_k) begin
      k_q <= k_next;
    end
  end

  // next neighbor that lies inside the image
  always_comb begin
    k_next   = k_q;
    nb_avail = 1'b0;
    for (int j = 4; j >= 1; j--) begin
      if (nb_ok_q[j-1] && (3'(j) > k_q)) begin
        k_next   = pea_pkg::lookup_t'(3'(j));
        nb_avail = 1'b1;
      end
    end
  end

  logic [31:0] lk_full;
  always_comb begin
    case (k_q)
      pea_pkg::LK_CENTER: lk_full = 32'(pos_q);
      pea_pkg::LK_RIGHT:  lk_full = 32'(pos_q) + 32'(h_eff);
      pea_pkg::LK_LEFT:   lk_full = 32'(pos_q) - 32'(h_eff);
      pea_pkg::LK_BELOW:  lk_full = 32'(pos_q) + 32'd1;
      pea_pkg::LK_ABOVE:  lk_full = 32'(pos_q) - 32'd1;
      default:            lk_full = 32'(pos_q);
    endcase
  end

  // memories
  logic [7:0]  src_mem [SRC_DEPTH];
  logic [31:0] pal_mem [256];
  logic [7:0]  src_q;
  logic [31:0] pal_q;

  always_ff @(posedge clk) begin
    if (cmd.src_we) src_mem[src_waddr] <= data_q[7:0];
    if (cmd.src_rd) src_q <= src_mem[lk_full[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.pal_we) pal_mem[addr_q[7:0]] <= data_q;
    if (cmd.pal_rd) pal_q <= pal_mem[src_q];
  end

  // result
  logic [31:0] ctr_q;

  always_ff @(posedge clk) begin
    if (cmd.save_center) ctr_q <= pal_q;
  end

  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      pea_pkg::RES_ZERO: begin
        {blue, green, red} <= '0;
        alpha    <= '0;
        coord_ok <= 1'b0;
      end
      pea_pkg::RES_SELF: begin
        {blue, green, red} <= pal_q[23:0];
        alpha    <= pal_q[31:24];
        coord_ok <= 1'b1;
      end
      pea_pkg::RES_KEEP: begin
        {blue, green, red} <= ctr_q[23:0];
        alpha    <= ctr_q[31:24];
        coord_ok <= 1'b1;
      end
      pea_pkg::RES_NB: begin
        {blue, green, red} <= pal_q[23:0];
        alpha    <= ctr_q[31:24];
        coord_ok <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status.in_image  = in_image;
  assign status.opaque    = (pal_q[31:24] != 8'd0);
  assign status.nb_avail  = nb_avail;
  assign status.is_center = (k_q == pea_pkg::LK_CENTER);
  assign status.mod_last  = !mod_cnt;

endmodule

// ===== tb/tb_palette_expand_alpha_bleed.sv =====
// ----------------------------------------------------------------------------
// tb_palette_expand_alpha_bleed
// Loads palette entries and source indices, then reads pixels back under a
// range of image sizes. Each read is predicted, including the bleed of a
// transparent pixel's color from its first opaque neighbor. Reads are only
// issued once the pixel and all its in-image neighbors hold a written index.
// ----------------------------------------------------------------------------
module tb_palette_expand_alpha_bleed;

  localparam int SIDE  = 256;
  localparam int DEPTH = SIDE * SIDE;

  typedef struct {
    pea_pkg::op_t                op;
    logic [pea_pkg::ADDR_W-1:0]  addr;
    logic [pea_pkg::DATA_W-1:0]  data;
    logic [pea_pkg::COORD_W-1:0] px;
    logic [pea_pkg::COORD_W-1:0] py;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       coord_ok;
  } pixel_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [pea_pkg::OP_W-1:0]      operation = '0;
  logic [pea_pkg::ADDR_W-1:0]    address = '0;
  logic [pea_pkg::DATA_W-1:0]    write_data = '0;
  logic [pea_pkg::COORD_W-1:0]   pixel_x = '0;
  logic [pea_pkg::COORD_W-1:0]   pixel_y = '0;
  logic                          done;
  logic [7:0]                    red, green, blue, alpha;
  logic                          coord_ok;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [pea_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pea_pkg::SIZE_W-1:0]    cfg_data = '0;

  palette_expand_alpha_bleed #(.MAX_SIDE(SIDE)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .address    (address),
    .write_data (write_data),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .coord_ok   (coord_ok),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // predictor state, updated on accepted items and register writes
  logic [31:0]                palette_mem [SIDE];
  logic [7:0]                 index_mem [DEPTH];
  logic [pea_pkg::SIZE_W-1:0] img_w = 1, img_h = 1;
  pixel_t                     pixel_q [$];

  // stimulus side bookkeeping
  pixel_cmd_t  cmd_q [$];
  bit          pal_known [SIDE];
  bit          src_known [DEPTH];
  logic [7:0]  pal_ids [$];
  int unsigned gen_w = 1, gen_h = 1;
  int          item_count, size_writes;
  bit          no_gaps;

  int          mismatches, reads_inside, reads_outside, reads_clear;
  bit          item_taken;
  int          gap_cnt;
  pixel_cmd_t  next_cmd;
  pixel_t      got, want;

  function automatic int unsigned clip_side(input logic [pea_pkg::SIZE_W-1:0] v);
    return (v > SIDE) ? SIDE : v;
  endfunction

  function automatic logic [31:0] lookup_color(input int unsigned x, y, h);
    return palette_mem[index_mem[(x * h + y) % DEPTH]];
  endfunction

  function automatic pixel_t expand_pixel(input logic [7:0] px, input logic [7:0] py);
    int unsigned w, h, x, y;
    logic [31:0] c, n;
    logic [23:0] rgb;
    pixel_t p;
    w = clip_side(img_w);
    h = clip_side(img_h);
    x = px;
    y = py;
    p = '0;
    if (x >= w || y >= h) return p;
    c = lookup_color(x, y, h);
    rgb = c[23:0];
    if (c[31:24] == 8'h00) begin
      // neighbors in order right, left, below, above; first opaque one wins
      n = '0;
      if (x + 1 < w) n = lookup_color(x + 1, y, h);
      if (n[31:24] == 8'h00 && x > 0) n = lookup_color(x - 1, y, h);
      if (n[31:24] == 8'h00 && y + 1 < h) n = lookup_color(x, y + 1, h);
      if (n[31:24] == 8'h00 && y > 0) n = lookup_color(x, y - 1, h);
      if (n[31:24] != 8'h00) rgb = n[23:0];
    end
    p.red      = rgb[7:0];
    p.green    = rgb[15:8];
    p.blue     = rgb[23:16];
    p.alpha    = c[31:24];
    p.coord_ok = 1'b1;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want_v, got_v);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  task automatic push_cmd(input pea_pkg::op_t op, input logic [pea_pkg::ADDR_W-1:0] addr,
                          input logic [pea_pkg::DATA_W-1:0] data,
                          input logic [pea_pkg::COORD_W-1:0] px, py);
    pixel_cmd_t c;
    c.op = op;
    c.addr = addr;
    c.data = data;
    c.px = px;
    c.py = py;
    cmd_q.push_back(c);
    if (op == pea_pkg::OP_PAL && !pal_known[addr[7:0]]) begin
      pal_known[addr[7:0]] = 1'b1;
      pal_ids.push_back(addr[7:0]);
    end
    if (op == pea_pkg::OP_SRC) src_known[addr % DEPTH] = 1'b1;
    if (op != pea_pkg::OP_NOP) item_count++;
  endtask

  function automatic logic [7:0] pick_color();
    return pal_ids[$urandom_range(0, pal_ids.size() - 1)];
  endfunction

  task automatic put_index(input logic [pea_pkg::ADDR_W-1:0] pos, input logic [7:0] idx);
    logic [31:0] d;
    d = $urandom;
    d[7:0] = idx;
    push_cmd(pea_pkg::OP_SRC, pos, d, pea_pkg::COORD_W'($urandom),
             pea_pkg::COORD_W'($urandom));
  endtask

  task automatic rand_palette();
    logic [31:0] d;
    logic [15:0] a;
    d = $urandom;
    a = 16'($urandom);
    case ($urandom_range(0, 4))
      0, 1: d[31:24] = 8'h00;
      2: d[31:24] = 8'hFF;
      default: ;
    endcase
    push_cmd(pea_pkg::OP_PAL, a, d, pea_pkg::COORD_W'($urandom),
             pea_pkg::COORD_W'($urandom));
  endtask

  task automatic ensure_index(input int unsigned x, y);
    if (!src_known[x * gen_h + y])
      put_index(pea_pkg::ADDR_W'(x * gen_h + y), pick_color());
  endtask

  // a read inside the image never touches an unwritten source entry
  task automatic read_pixel(input int unsigned x, y);
    if (x < gen_w && y < gen_h) begin
      ensure_index(x, y);
      if (x + 1 < gen_w) ensure_index(x + 1, y);
      if (x > 0) ensure_index(x - 1, y);
      if (y + 1 < gen_h) ensure_index(x, y + 1);
      if (y > 0) ensure_index(x, y - 1);
    end
    push_cmd(pea_pkg::OP_READ, pea_pkg::ADDR_W'($urandom), $urandom,
             pea_pkg::COORD_W'(x), pea_pkg::COORD_W'(y));
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || start || pixel_q.size() != 0) @(posedge clk);
    // writes give no result but may still be in progress
    repeat (24) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_size(input logic [pea_pkg::CFG_IDX_W-1:0] idx,
                            input logic [pea_pkg::SIZE_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == pea_pkg::REG_WIDTH) gen_w = clip_side(val);
    else gen_h = clip_side(val);
    size_writes++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!(start && !item_taken)) begin
      item_taken = 1'b0;
      if (gap_cnt != 0) begin
        start <= 1'b0;
        gap_cnt--;
      end else if (cmd_q.size() != 0) begin
        next_cmd = cmd_q.pop_front();
        operation  <= next_cmd.op;
        address    <= next_cmd.addr;
        write_data <= next_cmd.data;
        pixel_x    <= next_cmd.px;
        pixel_y    <= next_cmd.py;
        start      <= 1'b1;
        gap_cnt = no_gaps ? 0 : $urandom_range(0, 15);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      img_w = pea_pkg::SIZE_W'(1);
      img_h = pea_pkg::SIZE_W'(1);
    end else begin
      if (done) begin
        got.red      = red;
        got.green    = green;
        got.blue     = blue;
        got.alpha    = alpha;
        got.coord_ok = coord_ok;
        if (pixel_q.size() == 0) begin
          report_mismatch("result with no read pending", '0, {red, green, blue, alpha});
        end else begin
          want = pixel_q.pop_front();
          if (got.red !== want.red) report_mismatch("red", want.red, got.red);
          if (got.green !== want.green) report_mismatch("green", want.green, got.green);
          if (got.blue !== want.blue) report_mismatch("blue", want.blue, got.blue);
          if (got.alpha !== want.alpha) report_mismatch("alpha", want.alpha, got.alpha);
          if (got.coord_ok !== want.coord_ok)
            report_mismatch("coord_ok", want.coord_ok, got.coord_ok);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pea_pkg::REG_WIDTH) img_w = cfg_data;
        else img_h = cfg_data;
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        case (pea_pkg::op_t'(operation))
          pea_pkg::OP_PAL: palette_mem[address[7:0]] = write_data;
          pea_pkg::OP_SRC: index_mem[address % DEPTH] = write_data[7:0];
          pea_pkg::OP_READ: begin
            want = expand_pixel(pixel_x, pixel_y);
            pixel_q.push_back(want);
            if (!want.coord_ok) reads_outside++;
            else begin
              reads_inside++;
              if (want.alpha == 8'h00) reads_clear++;
            end
          end
          default: ;
        endcase
      end
    end
  end

  initial begin
    int unsigned ph, st, pick, w_set, h_set;
    int unsigned phase_w [7] = '{256, 0, 9, 511, 1, 256, 2};
    int unsigned phase_h [7] = '{256, 7, 0, 300, 256, 1, 2};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 1x1 image after reset; palette addresses above 255 wrap
    push_cmd(pea_pkg::OP_PAL, 16'h0000, 32'h0033_2211, 8'h00, 8'h00);
    push_cmd(pea_pkg::OP_PAL, 16'hFF01, 32'hFFCC_BBAA, 8'hFF, 8'hFF);
    push_cmd(pea_pkg::OP_PAL, 16'h00FF, 32'h80FF_FFFF, 8'h00, 8'h00);
    push_cmd(pea_pkg::OP_PAL, 16'hFFFE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_cmd(pea_pkg::OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    put_index(16'd0, 8'd0);
    read_pixel(0, 0);     // transparent, no neighbor: keeps own color
    read_pixel(1, 0);
    read_pixel(0, 1);
    read_pixel(255, 255);
    wait_idle();

    // 3x3: walk the bleed order around the center pixel
    write_size(pea_pkg::REG_WIDTH, 9'd3);
    write_size(pea_pkg::REG_HEIGHT, 9'd3);
    put_index(16'd4, 8'd0);
    put_index(16'd7, 8'd0);
    put_index(16'd1, 8'd0);
    put_index(16'd5, 8'd0);
    put_index(16'd3, 8'd1);
    read_pixel(1, 1);     // above
    put_index(16'd5, 8'd255);
    read_pixel(1, 1);     // below
    put_index(16'd1, 8'd254);
    read_pixel(1, 1);     // left
    put_index(16'd7, 8'd1);
    read_pixel(1, 1);     // right
    read_pixel(2, 1);     // opaque pixel as is
    wait_idle();

    ph = 0;
    while (item_count < 1050) begin
      if (ph < 7) begin
        w_set = phase_w[ph];
        h_set = phase_h[ph];
      end else if (ph % 4 == 3) begin
        w_set = $urandom_range(0, 511);
        h_set = $urandom_range(0, 511);
      end else begin
        w_set = $urandom_range(1, 24);
        h_set = $urandom_range(1, 24);
      end
      write_size(pea_pkg::REG_WIDTH, pea_pkg::SIZE_W'(w_set));
      write_size(pea_pkg::REG_HEIGHT, pea_pkg::SIZE_W'(h_set));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (3) rand_palette();
      for (st = 0; st < 80 && item_count < 1050; st++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55 && gen_w != 0 && gen_h != 0)
          read_pixel($urandom_range(0, gen_w - 1), $urandom_range(0, gen_h - 1));
        else if (pick < 65)
          read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
        else if (pick < 75 && gen_w != 0 && gen_h != 0)
          put_index(pea_pkg::ADDR_W'($urandom_range(0, gen_w - 1) * gen_h +
                                     $urandom_range(0, gen_h - 1)),
                    pick_color());
        else if (pick < 85)
          rand_palette();
        else if (pick < 92)
          put_index(pea_pkg::ADDR_W'($urandom), pick_color());
        else if (pick < 97 && gen_w != 0 && gen_h != 0)
          // edges and corners, where neighbors are missing
          read_pixel($urandom_range(0, 1) ? 0 : gen_w - 1,
                     $urandom_range(0, 1) ? 0 : gen_h - 1);
        else
          push_cmd(pea_pkg::OP_NOP, pea_pkg::ADDR_W'($urandom), $urandom,
                   pea_pkg::COORD_W'($urandom), pea_pkg::COORD_W'($urandom));
      end
      wait_idle();
      ph++;
    end

    wait_idle();
    if (pixel_q.size() != 0)
      report_mismatch("reads left without result", '0, pixel_q.size());
    $display("Ran %0d items over %0d size writes", item_count, size_writes);
    $display("Reads: %0d inside (%0d transparent), %0d outside",
             reads_inside, reads_clear, reads_outside);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
